### rtl/stt_pkg.sv
// Package for the source text tokenizer: beat structs, token kinds, lexer modes,
// and the character class and keyword helpers. No dependencies.
package stt_pkg;

  localparam int unsigned PosBits  = 16;
  localparam int unsigned OffBits  = 32;
  localparam int unsigned KwChars  = 8;
  localparam int unsigned WordBits = 8 * KwChars;
  localparam int unsigned MaxRes   = 3;
  localparam int unsigned CntBits  = 2;

  localparam logic [5:0] KNumber  = 6'd0;
  localparam logic [5:0] KString  = 6'd1;
  localparam logic [5:0] KIdent   = 6'd2;
  localparam logic [5:0] KKw0     = 6'd3;
  localparam logic [5:0] KComment = 6'd11;
  localparam logic [5:0] KPlus    = 6'd12;
  localparam logic [5:0] KMinus   = 6'd13;
  localparam logic [5:0] KStar    = 6'd14;
  localparam logic [5:0] KSlash   = 6'd15;
  localparam logic [5:0] KEq      = 6'd16;
  localparam logic [5:0] KEqEq    = 6'd17;
  localparam logic [5:0] KNotEq   = 6'd18;
  localparam logic [5:0] KLess    = 6'd19;
  localparam logic [5:0] KLessEq  = 6'd20;
  localparam logic [5:0] KGt      = 6'd21;
  localparam logic [5:0] KGtEq    = 6'd22;
  localparam logic [5:0] KLParen  = 6'd23;
  localparam logic [5:0] KRParen  = 6'd24;
  localparam logic [5:0] KLBrack  = 6'd25;
  localparam logic [5:0] KRBrack  = 6'd26;
  localparam logic [5:0] KLBrace  = 6'd27;
  localparam logic [5:0] KRBrace  = 6'd28;
  localparam logic [5:0] KComma   = 6'd29;
  localparam logic [5:0] KDot     = 6'd30;
  localparam logic [5:0] KColon   = 6'd31;
  localparam logic [5:0] KError   = 6'd32;
  localparam logic [5:0] KEof     = 6'd33;

  typedef enum logic [2:0] {
    ModeIdle, ModeNumber, ModeIdent, ModeString, ModeComment, ModeCommentLt, ModeOp
  } mode_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       end_of_input;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] tok_line;
    logic [15:0] start_column;
    logic [31:0] value_offset;
    logic [15:0] value_length;
    logic [7:0]  token_char;
    logic        last_token;
  } out_beat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      "+": k = KPlus;
      "-": k = KMinus;
      "*": k = KStar;
      "/": k = KSlash;
      "=": k = KEq;
      "<": k = KLess;
      ">": k = KGt;
      "(": k = KLParen;
      ")": k = KRParen;
      "[": k = KLBrack;
      "]": k = KRBrack;
      "{": k = KLBrace;
      "}": k = KRBrace;
      ",": k = KComma;
      ".": k = KDot;
      ":": k = KColon;
      default: k = KError;
    endcase
    return k;
  endfunction

  // Keyword lookup on the right-aligned word buffer and the token length.
  // Words longer than the buffer are never keywords.
  function automatic logic [5:0] ident_kind(input logic [WordBits-1:0] w,
                                            input logic [15:0] len);
    logic [5:0] k;
    k = KIdent;
    if (len <= 16'(KwChars)) begin
      if (len == 16'd2 && w == WordBits'("if"))           k = KKw0;
      if (len == 16'd4 && w == WordBits'("else"))         k = KKw0 + 6'd1;
      if (len == 16'd4 && w == WordBits'("loop"))         k = KKw0 + 6'd2;
      if (len == 16'd6 && w == WordBits'("repeat"))       k = KKw0 + 6'd3;
      if (len == 16'd8 && w == WordBits'("function"))     k = KKw0 + 6'd4;
      if (len == 16'd6 && w == WordBits'("return"))       k = KKw0 + 6'd5;
      if (len == 16'd6 && w == WordBits'("output"))       k = KKw0 + 6'd6;
      if (len == 16'd5 && w == WordBits'("input"))        k = KKw0 + 6'd7;
    end
    return k;
  endfunction

endpackage

### rtl/stt_lexer.sv
// Lexer core: state registers and the per-byte next-state and token logic.
// Depends on stt_pkg.
module stt_lexer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  stt_pkg::in_beat_t      beat_i,
  output logic [stt_pkg::CntBits-1:0] cnt_o,
  output stt_pkg::out_beat_t     tok0_o,
  output stt_pkg::out_beat_t     tok1_o,
  output stt_pkg::out_beat_t     tok2_o
);
  localparam logic [stt_pkg::PosBits-1:0] PosMax = '1;

  stt_pkg::mode_e mode_q, mode_d;
  logic [stt_pkg::PosBits-1:0] line_q, line_d, col_q, col_d, sline_q, sline_d, scol_q, scol_d;
  logic [stt_pkg::OffBits-1:0] off_q, off_d, toff_q, toff_d;
  logic [15:0] tlen_q, tlen_d;
  logic [stt_pkg::WordBits-1:0] word_q, word_d;
  logic [7:0] pend_q, pend_d;
  logic fin_q, fin_d;

  stt_pkg::out_beat_t toks [stt_pkg::MaxRes];
  logic [stt_pkg::CntBits-1:0] n;

  always_comb begin
    logic [7:0] c;
    logic       go_idle, eof;
    logic [5:0] k;
    mode_d = mode_q; line_d = line_q; col_d = col_q; off_d = off_q;
    sline_d = sline_q; scol_d = scol_q; toff_d = toff_q; tlen_d = tlen_q;
    word_d = word_q; pend_d = pend_q; fin_d = fin_q;
    n = '0;
    for (int i = 0; i < stt_pkg::MaxRes; i++) toks[i] = '0;
    c = beat_i.char_code;
    go_idle = 1'b0;
    eof = 1'b0;
    k = '0;
    if (step_i && !fin_q) begin
      eof = beat_i.end_of_input || (beat_i.has_char && c == 8'd0);
      if (beat_i.has_char && c != 8'd0) begin
        unique case (mode_q)
          stt_pkg::ModeNumber: begin
            if (stt_pkg::is_digit(c) || c == ".") begin
              if (tlen_d != 16'hFFFF) tlen_d = tlen_q + 16'd1;
            end else begin
              toks[n] = '{stt_pkg::KNumber, 16'(sline_q), 16'(scol_q), 32'(toff_q),
                          tlen_q, 8'd0, 1'b0};
              n = n + 1'b1;
              go_idle = 1'b1;
            end
          end
          stt_pkg::ModeIdent: begin
            if (stt_pkg::is_alpha(c) || stt_pkg::is_digit(c) || c == "_") begin
              word_d = {word_q[stt_pkg::WordBits-9:0], c};
              if (tlen_d != 16'hFFFF) tlen_d = tlen_q + 16'd1;
            end else begin
              toks[n] = '{stt_pkg::ident_kind(word_q, tlen_q), 16'(sline_q), 16'(scol_q),
                          32'(toff_q), tlen_q, 8'd0, 1'b0};
              n = n + 1'b1;
              go_idle = 1'b1;
            end
          end
          stt_pkg::ModeString: begin
            if (c == "\"") begin
              toks[n] = '{stt_pkg::KString, 16'(sline_q), 16'(scol_q), 32'(toff_q),
                          tlen_q, 8'd0, 1'b0};
              n = n + 1'b1;
              mode_d = stt_pkg::ModeIdle;
            end else if (tlen_q != 16'hFFFF) tlen_d = tlen_q + 16'd1;
          end
          stt_pkg::ModeComment: begin
            if (c == "<") mode_d = stt_pkg::ModeCommentLt;
            else if (tlen_q != 16'hFFFF) tlen_d = tlen_q + 16'd1;
          end
          stt_pkg::ModeCommentLt: begin
            if (c == "<") begin
              toks[n] = '{stt_pkg::KComment, 16'(sline_q), 16'(scol_q), 32'(toff_q),
                          tlen_q, 8'd0, 1'b0};
              n = n + 1'b1;
              mode_d = stt_pkg::ModeIdle;
            end else begin
              // the held '<' and this byte both join the text
              tlen_d = (tlen_q >= 16'hFFFE) ? 16'hFFFF : tlen_q + 16'd2;
              mode_d = stt_pkg::ModeComment;
            end
          end
          stt_pkg::ModeOp: begin
            if (pend_q == ">" && c == ">") begin
              toff_d = off_q + 1'b1;
              tlen_d = '0;
              mode_d = stt_pkg::ModeComment;
            end else if (c == "=") begin
              priority if (pend_q == "=") k = stt_pkg::KEqEq;
              else if (pend_q == "!") k = stt_pkg::KNotEq;
              else if (pend_q == "<") k = stt_pkg::KLessEq;
              else k = stt_pkg::KGtEq;
              toks[n] = '{k, 16'(sline_q), 16'(scol_q), 32'(off_q), 16'd1, c, 1'b0};
              n = n + 1'b1;
              mode_d = stt_pkg::ModeIdle;
            end else begin
              toks[n] = '{stt_pkg::single_kind(pend_q), 16'(sline_q), 16'(scol_q),
                          32'(toff_q), 16'd1, pend_q, 1'b0};
              n = n + 1'b1;
              go_idle = 1'b1;
            end
          end
          default: go_idle = 1'b1;
        endcase
        if (go_idle) begin
          mode_d = stt_pkg::ModeIdle;
          if (!stt_pkg::is_space(c)) begin
            sline_d = line_q; scol_d = col_q; toff_d = off_q; tlen_d = '0; word_d = '0;
            if (stt_pkg::is_digit(c)) begin
              tlen_d = 16'd1; mode_d = stt_pkg::ModeNumber;
            end else if (c == "\"") begin
              toff_d = off_q + 1'b1; mode_d = stt_pkg::ModeString;
            end else if (stt_pkg::is_alpha(c) || c == "_") begin
              tlen_d = 16'd1; word_d = stt_pkg::WordBits'(c); mode_d = stt_pkg::ModeIdent;
            end else if (c == "=" || c == "!" || c == "<" || c == ">") begin
              pend_d = c; mode_d = stt_pkg::ModeOp;
            end else begin
              toks[n] = '{stt_pkg::single_kind(c), 16'(line_q), 16'(col_q), 32'(off_q),
                          16'd1, c, 1'b0};
              n = n + 1'b1;
            end
          end
        end
        // position advance
        if (c == 8'h0A) begin
          if (line_q != PosMax) line_d = line_q + 1'b1;
          col_d = stt_pkg::PosBits'(1);
        end else if (col_q != PosMax) col_d = col_q + 1'b1;
        off_d = off_q + 1'b1;
      end
      if (eof) begin
        unique case (mode_d)
          stt_pkg::ModeNumber, stt_pkg::ModeString, stt_pkg::ModeComment,
          stt_pkg::ModeCommentLt: begin
            if (mode_d == stt_pkg::ModeNumber) k = stt_pkg::KNumber;
            else if (mode_d == stt_pkg::ModeString) k = stt_pkg::KString;
            else k = stt_pkg::KComment;
            toks[n] = '{k, 16'(sline_d), 16'(scol_d), 32'(toff_d),
                        (mode_d == stt_pkg::ModeCommentLt && tlen_d != 16'hFFFF) ?
                        tlen_d + 16'd1 : tlen_d, 8'd0, 1'b0};
            n = n + 1'b1;
          end
          stt_pkg::ModeIdent: begin
            toks[n] = '{stt_pkg::ident_kind(word_d, tlen_d), 16'(sline_d), 16'(scol_d),
                        32'(toff_d), tlen_d, 8'd0, 1'b0};
            n = n + 1'b1;
          end
          stt_pkg::ModeOp: begin
            toks[n] = '{stt_pkg::single_kind(pend_d), 16'(sline_d), 16'(scol_d),
                        32'(toff_d), 16'd1, pend_d, 1'b0};
            n = n + 1'b1;
          end
          default: ;
        endcase
        toks[n] = '{stt_pkg::KEof, 16'(line_d), 16'(col_d), 32'(off_d), 16'd0, 8'd0, 1'b1};
        n = n + 1'b1;
        mode_d = stt_pkg::ModeIdle;
        fin_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= stt_pkg::ModeIdle;
      line_q <= stt_pkg::PosBits'(1); col_q <= stt_pkg::PosBits'(1); off_q <= '0;
      sline_q <= stt_pkg::PosBits'(1); scol_q <= stt_pkg::PosBits'(1);
      toff_q <= '0; tlen_q <= '0;
      word_q <= '0; pend_q <= '0; fin_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      line_q <= line_d; col_q <= col_d; off_q <= off_d;
      sline_q <= sline_d; scol_q <= scol_d; toff_q <= toff_d; tlen_q <= tlen_d;
      word_q <= word_d; pend_q <= pend_d; fin_q <= fin_d;
    end
  end

  assign cnt_o  = n;
  assign tok0_o = toks[0];
  assign tok1_o = toks[1];
  assign tok2_o = toks[2];
endmodule

### rtl/stt_out_queue.sv
// Result queue: takes up to three tokens per cycle; one beat leaves per cycle with ready_i.
// Depends on stt_pkg.
module stt_out_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [stt_pkg::CntBits-1:0] cnt_i,
  input  stt_pkg::out_beat_t          tok0_i,
  input  stt_pkg::out_beat_t          tok1_i,
  input  stt_pkg::out_beat_t          tok2_i,
  output logic                        room_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output stt_pkg::out_beat_t          data_o
);
  localparam int unsigned Depth = 8;
  localparam int unsigned AW    = $clog2(Depth);

  stt_pkg::out_beat_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q, cnt_d;
  logic          pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rp_q];
  // room for a full burst of three on top of what this cycle writes and pops
  assign room_o  = cnt_d <= (AW+1)'(Depth - stt_pkg::MaxRes);
  assign cnt_d   = cnt_q + (AW+1)'(cnt_i) - (AW+1)'(pop);

  always_ff @(posedge clk_i) begin
    if (cnt_i > 2'd0) mem_q[wp_q]          <= tok0_i;
    if (cnt_i > 2'd1) mem_q[wp_q + AW'(1)] <= tok1_i;
    if (cnt_i > 2'd2) mem_q[wp_q + AW'(2)] <= tok2_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + AW'(cnt_i);
      rp_q  <= rp_q + AW'(pop);
      cnt_q <= cnt_d;
    end
  end
endmodule

### rtl/source_text_tokenizer_unit.sv
// Source text tokenizer top level: input register, lexer core, result queue.
// Depends on stt_pkg, stt_lexer, stt_out_queue.
// Path: input register, then the combinational lexer core, then the registered queue.
// Throughput: one byte per cycle while the eight-entry queue can absorb a
// three-token burst; tokens drain one per cycle when taken, so long bursts stall input.
// Reset: asynchronous, active low; line and column restart at 1, offset at 0.
module source_text_tokenizer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  stt_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stt_pkg::out_beat_t out_data_o
);
  // input register
  logic               ib_valid_q;
  stt_pkg::in_beat_t  ib_data_q;
  logic               room;
  logic [stt_pkg::CntBits-1:0] cnt;
  stt_pkg::out_beat_t t0, t1, t2;

  // accept when the queue can absorb a worst-case burst from the held beat too
  assign in_ready_o = room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ib_valid_q <= 1'b0;
    else         ib_valid_q <= in_valid_i && in_ready_o;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) ib_data_q <= in_data_i;
  end

  stt_lexer u_lexer (
    .clk_i, .rst_ni,
    .step_i(ib_valid_q), .beat_i(ib_data_q),
    .cnt_o(cnt), .tok0_o(t0), .tok1_o(t1), .tok2_o(t2)
  );

  stt_out_queue u_queue (
    .clk_i, .rst_ni,
    .cnt_i(cnt), .tok0_i(t0), .tok1_i(t1), .tok2_i(t2),
    .room_o(room), .valid_o(out_valid_o), .ready_i(out_ready_i), .data_o(out_data_o)
  );
endmodule

### sim/source_text_tokenizer_unit_tb.sv
// Testbench for source_text_tokenizer_unit: drives byte beats, predicts tokens
// with an in-bench lexer model and checks each token beat. Depends on stt_pkg.
module source_text_tokenizer_unit_tb;

  localparam int unsigned WatchdogLimit = 20000;
  localparam logic [15:0] PosMax = 16'hFFFF;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  stt_pkg::in_beat_t in_data_i;
  stt_pkg::out_beat_t out_data_o;

  source_text_tokenizer_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Lexer state of the token predictor.
  stt_pkg::mode_e lx_mode;
  logic [15:0] lx_line, lx_col, lx_tline, lx_tcol, lx_tlen;
  logic [31:0] lx_off, lx_toff;
  logic [63:0] lx_word;
  logic [7:0]  lx_pend;
  logic        lx_done;

  stt_pkg::out_beat_t expected_tokens[$];
  int          errors = 0;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  int          quiet_cycles = 0;

  function automatic bit c_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit c_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic bit c_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [5:0] op_kind(logic [7:0] c);
    case (c)
      "+": return stt_pkg::KPlus;
      "-": return stt_pkg::KMinus;
      "*": return stt_pkg::KStar;
      "/": return stt_pkg::KSlash;
      "=": return stt_pkg::KEq;
      "<": return stt_pkg::KLess;
      ">": return stt_pkg::KGt;
      "(": return stt_pkg::KLParen;
      ")": return stt_pkg::KRParen;
      "[": return stt_pkg::KLBrack;
      "]": return stt_pkg::KRBrack;
      "{": return stt_pkg::KLBrace;
      "}": return stt_pkg::KRBrace;
      ",": return stt_pkg::KComma;
      ".": return stt_pkg::KDot;
      ":": return stt_pkg::KColon;
      default: return stt_pkg::KError;
    endcase
  endfunction

  task automatic push_token(logic [5:0] k, logic [15:0] ln, logic [15:0] col,
                            logic [31:0] off, logic [15:0] len, logic [7:0] ch,
                            logic last);
    stt_pkg::out_beat_t t;
    t.token_kind = k; t.tok_line = ln; t.start_column = col;
    t.value_offset = off; t.value_length = len; t.token_char = ch;
    t.last_token = last;
    expected_tokens = {expected_tokens, t};
  endtask

  task automatic push_pending(logic [5:0] k);
    push_token(k, lx_tline, lx_tcol, lx_toff, lx_tlen, 8'd0, 1'b0);
  endtask

  task automatic push_word();
    logic [5:0] k;
    string kw[8] = '{"if", "else", "loop", "repeat", "function", "return",
                     "output", "input"};
    logic [63:0] w;
    k = stt_pkg::KIdent;
    if (lx_tlen <= 16'd8)
      for (int i = 0; i < 8; i++) begin
        w = '0;
        for (int j = 0; j < kw[i].len(); j++) w = {w[55:0], kw[i][j]};
        if (k == stt_pkg::KIdent && kw[i].len() == lx_tlen && w == lx_word)
          k = stt_pkg::KKw0 + 6'(i);
      end
    push_pending(k);
  endtask

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == PosMax) ? v : v + 16'd1;
  endfunction

  task automatic move_pos(logic [7:0] c);
    if (c == 8'h0A) begin
      lx_line = sat_inc(lx_line);
      lx_col  = 16'd1;
    end else begin
      lx_col = sat_inc(lx_col);
    end
    lx_off = lx_off + 32'd1;
  endtask

  task automatic lex_idle(logic [7:0] c);
    if (c_space(c)) begin
      move_pos(c);
      return;
    end
    lx_tline = lx_line; lx_tcol = lx_col; lx_toff = lx_off;
    lx_tlen = '0; lx_word = '0;
    if (c_digit(c)) begin
      lx_tlen = 16'd1; lx_mode = stt_pkg::ModeNumber;
    end else if (c == "\"") begin
      lx_toff = lx_off + 32'd1; lx_mode = stt_pkg::ModeString;
    end else if (c_alpha(c) || c == "_") begin
      lx_tlen = 16'd1; lx_word = {56'd0, c}; lx_mode = stt_pkg::ModeIdent;
    end else if (c == "=" || c == "!" || c == "<" || c == ">") begin
      lx_pend = c; lx_mode = stt_pkg::ModeOp;
    end else begin
      push_token(op_kind(c), lx_line, lx_col, lx_off, 16'd1, c, 1'b0);
    end
    move_pos(c);
  endtask

  task automatic lex_byte(logic [7:0] c);
    logic [5:0] k;
    case (lx_mode)
      stt_pkg::ModeNumber: begin
        if (c_digit(c) || c == ".") begin
          lx_tlen = sat_inc(lx_tlen); move_pos(c); return;
        end
        push_pending(stt_pkg::KNumber);
      end
      stt_pkg::ModeIdent: begin
        if (c_alpha(c) || c_digit(c) || c == "_") begin
          lx_word = {lx_word[55:0], c}; lx_tlen = sat_inc(lx_tlen);
          move_pos(c); return;
        end
        push_word();
      end
      stt_pkg::ModeString: begin
        if (c == "\"") begin
          push_pending(stt_pkg::KString); lx_mode = stt_pkg::ModeIdle;
        end else lx_tlen = sat_inc(lx_tlen);
        move_pos(c);
        return;
      end
      stt_pkg::ModeComment: begin
        if (c == "<") lx_mode = stt_pkg::ModeCommentLt;
        else lx_tlen = sat_inc(lx_tlen);
        move_pos(c);
        return;
      end
      stt_pkg::ModeCommentLt: begin
        if (c == "<") begin
          push_pending(stt_pkg::KComment); lx_mode = stt_pkg::ModeIdle;
        end else begin
          lx_tlen = sat_inc(sat_inc(lx_tlen)); lx_mode = stt_pkg::ModeComment;
        end
        move_pos(c);
        return;
      end
      stt_pkg::ModeOp: begin
        if (lx_pend == ">" && c == ">") begin
          lx_toff = lx_off + 32'd1; lx_tlen = '0; lx_mode = stt_pkg::ModeComment;
          move_pos(c); return;
        end
        if (c == "=") begin
          if (lx_pend == "=") k = stt_pkg::KEqEq;
          else if (lx_pend == "!") k = stt_pkg::KNotEq;
          else if (lx_pend == "<") k = stt_pkg::KLessEq;
          else k = stt_pkg::KGtEq;
          push_token(k, lx_tline, lx_tcol, lx_off, 16'd1, c, 1'b0);
          lx_mode = stt_pkg::ModeIdle; move_pos(c); return;
        end
        push_token(op_kind(lx_pend), lx_tline, lx_tcol, lx_toff, 16'd1, lx_pend, 1'b0);
      end
      default: ;
    endcase
    lx_mode = stt_pkg::ModeIdle;
    lex_idle(c);
  endtask

  task automatic lex_flush();
    case (lx_mode)
      stt_pkg::ModeNumber:    push_pending(stt_pkg::KNumber);
      stt_pkg::ModeIdent:     push_word();
      stt_pkg::ModeString:    push_pending(stt_pkg::KString);
      stt_pkg::ModeComment:   push_pending(stt_pkg::KComment);
      stt_pkg::ModeCommentLt: begin
        lx_tlen = sat_inc(lx_tlen); push_pending(stt_pkg::KComment);
      end
      stt_pkg::ModeOp: push_token(op_kind(lx_pend), lx_tline, lx_tcol, lx_toff, 16'd1,
                                  lx_pend, 1'b0);
      default: ;
    endcase
    push_token(stt_pkg::KEof, lx_line, lx_col, lx_off, 16'd0, 8'd0, 1'b1);
    lx_mode = stt_pkg::ModeIdle;
    lx_done = 1'b1;
  endtask

  task automatic predict_tokens(stt_pkg::in_beat_t b);
    if (lx_done) return;
    if (b.has_char) begin
      if (b.char_code == 8'd0) begin
        lex_flush();
        return;
      end
      lex_byte(b.char_code);
    end
    if (b.end_of_input) lex_flush();
  endtask

  // Send one beat; the predictor runs on acceptance. Valid stays up after
  // acceptance so the next beat can follow at once; idle gaps drop it.
  task automatic send_beat(logic [7:0] c, logic has, logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{char_code: c, has_char: has, end_of_input: eoi};
    do @(posedge clk_i); while (!in_ready_o);
    predict_tokens(in_data_i);
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b1, 1'b0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_tokens.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // The block only takes new text after reset, so after each end of file the
  // rest of the run feeds beats that must be ignored; every other test runs
  // before the end of file is sent.
  task automatic test_directed();
    send_text("if else loop repeat function return output input iffy functions\n");
    send_text("12.3.4 _a9Z \"str\" >>c<x<< + - * / = == != < <= > >= >>=<< ! ( ) [ ] { } , . :");
    send_beat(8'd1, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h80, 1'b1, 1'b0);
    send_beat(8'h7F, 1'b1, 1'b0);
    send_beat(8'h55, 1'b0, 1'b0);   // empty beat, ignored
    send_text("\t\v\f\r \n");
    drain();   // sender holds off until every token has come
  endtask

  task automatic test_random(int n);
    string frag[] = '{"if", "return", "input", "x1_", "007.5", "\"a b\"", ">>z<y<<",
                      "<=", ">=", "==", "!=", "!", "(", "\n", " ", "abcdefghij"};
    int k;
    for (int i = 0; i < n; ) begin
      k = $urandom_range(9);
      if (k < 6) begin
        send_text(frag[$urandom_range(frag.size() - 1)]);
        i += 3;
      end else begin
        send_beat(8'($urandom_range(1, 255)), 1'b1, 1'b0);
        i++;
      end
    end
  endtask

  task automatic test_open_end();
    // Comment left open with a lone '<' before an empty final beat that
    // carries the end flag.
    send_text(">>open<");
    send_beat("x", 1'b0, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);   // ignored after end of file
    send_beat("a", 1'b1, 1'b0);     // ignored after end of file
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    lx_mode = stt_pkg::ModeIdle; lx_line = 16'd1; lx_col = 16'd1; lx_off = '0;
    lx_tline = 16'd1; lx_tcol = 16'd1; lx_toff = '0; lx_tlen = '0;
    lx_word = '0; lx_pend = '0; lx_done = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = (p == 1 || p == 3) ? (p == 1 ? 51 : 33) : 0;
      recv_stall_pct = (p == 2) ? 51 : (p == 3 ? 33 : 0);
      test_random(35);
    end
    test_open_end();
    drain();
    if (errors == 0) $display("source_text_tokenizer_unit_tb: PASS");
    else $display("source_text_tokenizer_unit_tb: FAIL");
    $finish;
  end

  // Receiver stalls and token checking.
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    stt_pkg::out_beat_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected token beat kind %0d", out_data_o.token_kind);
        errors++;
      end else begin
        e = expected_tokens.pop_front();
        if (out_data_o.token_kind !== e.token_kind) begin
          $error("token_kind exp %0d got %0d", e.token_kind, out_data_o.token_kind);
          errors++;
        end
        if (out_data_o.tok_line !== e.tok_line) begin
          $error("tok_line exp %0d got %0d", e.tok_line, out_data_o.tok_line);
          errors++;
        end
        if (out_data_o.start_column !== e.start_column) begin
          $error("start_column exp %0d got %0d", e.start_column,
                 out_data_o.start_column);
          errors++;
        end
        if (out_data_o.value_offset !== e.value_offset) begin
          $error("value_offset exp %0d got %0d", e.value_offset,
                 out_data_o.value_offset);
          errors++;
        end
        if (out_data_o.value_length !== e.value_length) begin
          $error("value_length exp %0d got %0d", e.value_length,
                 out_data_o.value_length);
          errors++;
        end
        if (out_data_o.token_char !== e.token_char) begin
          $error("token_char exp %0h got %0h", e.token_char, out_data_o.token_char);
          errors++;
        end
        if (out_data_o.last_token !== e.last_token) begin
          $error("last_token exp %0d got %0d", e.last_token, out_data_o.last_token);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat accepted on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("source_text_tokenizer_unit_tb: FAIL");
      $finish;
    end
  end

endmodule
